[rtl/sorted_region_allocator_unit_assert.svh]
// Assertion helpers for the allocator RTL.
// All checks sample on the rising edge of clk and are off while arst_n is low.
`ifndef SORTED_REGION_ALLOCATOR_UNIT_ASSERT_SVH
`define SORTED_REGION_ALLOCATOR_UNIT_ASSERT_SVH

// Condition that must hold at every edge.
`define SRA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SRA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sra_pkg;

	// Commands carried by one input transfer
	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FIXED = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_GROW  = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADADDR  = 3'd2,
		ST_NOSPACE  = 3'd3,
		ST_OVERLAP  = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	// Configuration register indexes
	typedef enum logic {
		REG_BASE = 1'b0,
		REG_TOP  = 1'b1
	} reg_idx_t;

	localparam logic [31:0] BASE_RST = 32'h6000_0000;
	localparam logic [31:0] TOP_RST  = 32'h8000_0000;

	// One table entry as held in the region memory
	typedef struct packed {
		logic [31:0] start;
		logic [30:0] length;
	} region_t;

	// One result as handed from the sequencer to the output register
	typedef struct packed {
		status_t     status;
		logic [31:0] addr;
		logic [4:0]  slot;
		logic [5:0]  total;
	} res_t;

endpackage

`default_nettype wire

[rtl/sra_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module sra_mem #(
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output sra_pkg::region_t      rdata,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  sra_pkg::region_t      wdata
);
	import sra_pkg::*;

	region_t mem_q [DEPTH];
	region_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/sra_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_region_allocator_unit_assert.svh"

module sra_ctrl #(
	parameter int MAX_REGIONS = 32,
	parameter int PAGE_BYTES = 4096,
	localparam int IDX_W = $clog2(MAX_REGIONS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       cmd,
	input  wire logic [31:0]      req_addr,
	input  wire logic [30:0]      req_length,
	input  wire logic [4:0]       entry_index,
	input  wire logic [31:0]      base,
	input  wire logic [31:0]      top_lim,
	output logic                  mem_re,
	output logic [IDX_W-1:0]      mem_raddr,
	input  sra_pkg::region_t      mem_rdata,
	output logic                  mem_we,
	output logic [IDX_W-1:0]      mem_waddr,
	output sra_pkg::region_t      mem_wdata,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output sra_pkg::res_t         res
);
	import sra_pkg::*;

	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
	localparam int PG_W  = $clog2(PAGE_BYTES);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_PREP   = 11'b000_0000_0010,
		S_CHECK  = 11'b000_0000_0100,
		S_SCAN   = 11'b000_0000_1000,
		S_DECIDE = 11'b000_0001_0000,
		S_SHUP   = 11'b000_0010_0000,
		S_PUT    = 11'b000_0100_0000,
		S_SHDN   = 11'b000_1000_0000,
		S_GROW   = 11'b001_0000_0000,
		S_GDEC   = 11'b010_0000_0000,
		S_FIN    = 11'b100_0000_0000
	} state_t;

	// Round up to a whole page, one carry out kept
	function automatic logic [32:0] page_up(input logic [31:0] x);
		logic [32:0] s;
		s = {1'b0, x} + 33'(PAGE_BYTES - 1);
		return {s[32:PG_W], {PG_W{1'b0}}};
	endfunction

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              v_s1;
	logic [IDX_W-1:0]  ip_s1;

	cmd_t              cmd_q, cmd_d;
	logic [31:0]       addr_q, addr_d;
	logic [30:0]       len_q, len_d;
	logic [4:0]        idx_q, idx_d;
	logic [31:0]       plen_q, plen_d;
	logic [32:0]       ra_q, ra_d;
	logic [33:0]       rend_q, rend_d;
	logic [32:0]       start_q, start_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic              ovl_q, ovl_d;
	logic [CNT_W-1:0]  rp_q, rp_d;
	status_t           status_q, status_d;
	logic [31:0]       raddr_q, raddr_d;
	logic [IDX_W-1:0]  slot_q, slot_d;
	region_t           new_q, new_d;
	region_t           cur_q, cur_d;
	logic [32:0]       pucur_q, pucur_d;
	logic [31:0]       limit_q, limit_d;

	// Per-entry terms on the read data
	logic [32:0]       s33;
	logic [32:0]       pl33;
	logic [32:0]       e33;
	logic              fit;
	logic              ovl_hit;
	logic              last;
	logic [CNT_W-1:0]  idx_c;
	logic              idx_ok;
	logic [33:0]       ff_end;
	logic [31:0]       nlen;
	logic [33:0]       nend;
	logic              wr_phase;

	assign s33     = {1'b0, mem_rdata.start};
	assign pl33    = page_up({1'b0, mem_rdata.length});
	assign e33     = s33 + pl33;
	assign fit     = (s33 >= start_q) && ((s33 - start_q) >= {1'b0, plen_q});
	assign ovl_hit = ({1'b0, s33} < rend_q) && (e33 > ra_q);
	assign last    = (CNT_W'(ip_s1) == (count_q - 1'b1));
	assign idx_c   = CNT_W'(idx_q);
	assign idx_ok  = CMP_W'(idx_q) < CMP_W'(count_q);
	assign ff_end  = {1'b0, start_q} + {2'b0, plen_q};
	assign nlen    = {1'b0, cur_q.length} + 32'(PAGE_BYTES);
	assign nend    = {2'b0, cur_q.start} + {1'b0, pucur_q} + 34'(PAGE_BYTES);

	// Sequencer: check, scan, decide, shift, grow and write back
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cmd_d    = cmd_q;
		addr_d   = addr_q;
		len_d    = len_q;
		idx_d    = idx_q;
		plen_d   = plen_q;
		ra_d     = ra_q;
		rend_d   = rend_q;
		start_d  = start_q;
		pos_d    = pos_q;
		ovl_d    = ovl_q;
		rp_d     = rp_q;
		status_d = status_q;
		raddr_d  = raddr_q;
		slot_d   = slot_q;
		new_d    = new_q;
		cur_d    = cur_q;
		pucur_d  = pucur_q;
		limit_d  = limit_q;

		mem_re    = 1'b0;
		mem_raddr = rp_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;

		in_ready  = (state_q == S_IDLE);
		res_valid = (state_q == S_FIN);

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d    = cmd_t'(cmd);
					addr_d   = req_addr;
					len_d    = req_length;
					idx_d    = entry_index;
					status_d = ST_OK;
					raddr_d  = '0;
					slot_d   = '0;
					state_d  = S_PREP;
				end
			end

			S_PREP: begin
				plen_d  = 32'(page_up({1'b0, len_q}));
				ra_d    = page_up(addr_q);
				state_d = S_CHECK;
			end

			// Early checks and scan set-up
			S_CHECK: begin
				rend_d  = {1'b0, ra_q} + {2'b0, plen_q};
				start_d = {1'b0, base};
				pos_d   = count_q;
				ovl_d   = 1'b0;
				rp_d    = '0;
				unique case (cmd_q)
					CMD_ALLOC: begin
						if (count_q == CNT_W'(MAX_REGIONS)) begin
							status_d = ST_FULL;
							state_d  = S_FIN;
						end else if (len_q == '0) begin
							status_d = ST_BADADDR;
							state_d  = S_FIN;
						end else if (count_q == '0) begin
							state_d = S_DECIDE;
						end else begin
							state_d = S_SCAN;
						end
					end
					CMD_FIXED: begin
						if (count_q == CNT_W'(MAX_REGIONS)) begin
							status_d = ST_FULL;
							state_d  = S_FIN;
						end else if (len_q == '0) begin
							status_d = ST_BADADDR;
							state_d  = S_FIN;
						end else if (addr_q == '0 || addr_q < base || addr_q >= top_lim) begin
							status_d = ST_BADADDR;
							state_d  = S_FIN;
						end else if (({1'b0, ra_q} + {2'b0, plen_q}) > {2'b0, top_lim}) begin
							status_d = ST_BADADDR;
							state_d  = S_FIN;
						end else if (count_q == '0) begin
							state_d = S_DECIDE;
						end else begin
							state_d = S_SCAN;
						end
					end
					CMD_FREE: begin
						if (count_q == '0) begin
							status_d = ST_NOTFOUND;
							state_d  = S_FIN;
						end else begin
							state_d = S_SCAN;
						end
					end
					CMD_GROW: begin
						if (!idx_ok) begin
							status_d = ST_NOTFOUND;
							state_d  = S_FIN;
						end else begin
							rp_d    = idx_c;
							state_d = S_GROW;
						end
					end
					default: state_d = S_FIN;
				endcase
			end

			// Walk the sorted table, one entry a cycle
			S_SCAN: begin
				if (rp_q < count_q) begin
					mem_re = 1'b1;
					rp_d   = rp_q + 1'b1;
				end
				if (v_s1) begin
					unique case (cmd_q)
						CMD_ALLOC: begin
							if (fit) begin
								pos_d   = CNT_W'(ip_s1);
								state_d = S_DECIDE;
							end else begin
								if (e33 > start_q) begin
									start_d = e33;
								end
								if (last) begin
									pos_d   = count_q;
									state_d = S_DECIDE;
								end
							end
						end
						CMD_FIXED: begin
							if (ovl_hit) begin
								ovl_d = 1'b1;
							end
							if (pos_q == count_q && s33 > ra_q) begin
								pos_d = CNT_W'(ip_s1);
							end
							if (last) begin
								state_d = S_DECIDE;
							end
						end
						CMD_FREE: begin
							if (s33 == ra_q) begin
								raddr_d = mem_rdata.start;
								slot_d  = ip_s1;
								if (last) begin
									count_d = count_q - 1'b1;
									state_d = S_FIN;
								end else begin
									rp_d    = CNT_W'(ip_s1) + 1'b1;
									state_d = S_SHDN;
								end
							end else if (last) begin
								status_d = ST_NOTFOUND;
								state_d  = S_FIN;
							end
						end
						CMD_GROW: begin
							state_d = S_FIN;
						end
						default: state_d = S_FIN;
					endcase
				end
			end

			// Settle the allocation and open the slot
			S_DECIDE: begin
				if (cmd_q == CMD_ALLOC && ff_end > {2'b0, top_lim}) begin
					status_d = ST_NOSPACE;
					state_d  = S_FIN;
				end else if (cmd_q != CMD_ALLOC && ovl_q) begin
					status_d = ST_OVERLAP;
					state_d  = S_FIN;
				end else begin
					if (cmd_q == CMD_ALLOC) begin
						new_d.start = start_q[31:0];
						raddr_d     = start_q[31:0];
					end else begin
						new_d.start = ra_q[31:0];
						raddr_d     = ra_q[31:0];
					end
					new_d.length = len_q;
					slot_d       = pos_q[IDX_W-1:0];
					if (pos_q == count_q) begin
						state_d = S_PUT;
					end else begin
						rp_d    = count_q - 1'b1;
						state_d = S_SHUP;
					end
				end
			end

			// Move entries up by one, highest first
			S_SHUP: begin
				if (rp_q >= pos_q && rp_q < count_q) begin
					mem_re = 1'b1;
					rp_d   = rp_q - 1'b1;
				end
				if (v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ip_s1 + 1'b1;
					if (CNT_W'(ip_s1) == pos_q) begin
						state_d = S_PUT;
					end
				end
			end

			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[IDX_W-1:0];
				mem_wdata = new_q;
				count_d   = count_q + 1'b1;
				state_d   = S_FIN;
			end

			// Close the gap, lowest first
			S_SHDN: begin
				if (rp_q < count_q) begin
					mem_re = 1'b1;
					rp_d   = rp_q + 1'b1;
				end
				if (v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ip_s1 - 1'b1;
					if (last) begin
						count_d = count_q - 1'b1;
						state_d = S_FIN;
					end
				end
			end

			// Fetch the entry and its upper neighbour
			S_GROW: begin
				if (rp_q < count_q && (rp_q - idx_c) < CNT_W'(2)) begin
					mem_re = 1'b1;
					rp_d   = rp_q + 1'b1;
				end
				if (v_s1) begin
					if (CNT_W'(ip_s1) == idx_c) begin
						cur_d   = mem_rdata;
						pucur_d = pl33;
						if (last) begin
							limit_d = top_lim;
							state_d = S_GDEC;
						end
					end else begin
						limit_d = mem_rdata.start;
						state_d = S_GDEC;
					end
				end
			end

			S_GDEC: begin
				if (nlen[31] || nend > {2'b0, limit_q}) begin
					status_d = ST_NOSPACE;
				end else begin
					mem_we           = 1'b1;
					mem_waddr        = idx_c[IDX_W-1:0];
					mem_wdata.start  = cur_q.start;
					mem_wdata.length = nlen[30:0];
					raddr_d          = cur_q.start;
					slot_d           = idx_c[IDX_W-1:0];
				end
				state_d = S_FIN;
			end

			// Hand the result to the output register
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			v_s1    <= mem_re && (state_d == state_q);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		ip_s1    <= mem_raddr;
		cmd_q    <= cmd_d;
		addr_q   <= addr_d;
		len_q    <= len_d;
		idx_q    <= idx_d;
		plen_q   <= plen_d;
		ra_q     <= ra_d;
		rend_q   <= rend_d;
		start_q  <= start_d;
		pos_q    <= pos_d;
		ovl_q    <= ovl_d;
		rp_q     <= rp_d;
		status_q <= status_d;
		raddr_q  <= raddr_d;
		slot_q   <= slot_d;
		new_q    <= new_d;
		cur_q    <= cur_d;
		pucur_q  <= pucur_d;
		limit_q  <= limit_d;
	end

	assign res.status = status_q;
	assign res.addr   = raddr_q;
	assign res.slot   = 5'(slot_q);
	assign res.total  = 6'(count_q);

	// States that may write the table
	assign wr_phase = (state_q == S_PUT) || (state_q == S_SHUP) ||
		(state_q == S_SHDN) || (state_q == S_GDEC);

	`SRA_ASSERT_ALWAYS(a_count_max, count_q <= CNT_W'(MAX_REGIONS), "region count over capacity")
	`SRA_ASSERT_IMP(a_rw_apart, mem_re && mem_we, mem_raddr != mem_waddr, "read and write collide")
	`SRA_ASSERT_IMP(a_we_state, mem_we, wr_phase, "write outside update")
	`SRA_ASSERT_NEXT(a_idle_count, state_q == S_IDLE, $stable(count_q), "count moved while idle")

endmodule

`default_nettype wire

[rtl/sorted_region_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sorted region allocator: keeps up to MAX_REGIONS address regions (start, byte length)
// in one single-port-read, single-port-write memory, sorted by start, and serves one
// command at a time: first-fit allocate, fixed allocate, free by start and grow by a
// page. Each command gives exactly one result. An item occupies the sequencer until its
// result is handed on: the table scan reads one entry a cycle through the memory read
// port, and an insert or a free then moves the entries above the slot one a cycle
// through the write port. The next item is taken as soon as the result sits in the
// output register, even if it has not yet been collected. The memory needs no
// clearing after reset; region_base and region_top may be written only while no
// command is in flight.

module sorted_region_allocator_unit #(
	parameter int MAX_REGIONS = 32,
	parameter int PAGE_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] req_addr,
	input  wire logic [30:0] req_length,
	input  wire logic [4:0]  entry_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [31:0]      result_addr,
	output logic [4:0]       result_slot,
	output logic [5:0]       region_total,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	import sra_pkg::*;

	localparam int IDX_W = $clog2(MAX_REGIONS);

	logic [31:0]      base_q;
	logic [31:0]      top_q;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	region_t          mem_rdata;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	region_t          mem_wdata;
	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic             ov_q;
	res_t             or_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			top_q  <= TOP_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_BASE) begin
				base_q <= cfg_data;
			end else begin
				top_q <= cfg_data;
			end
		end
	end

	sra_mem #(
		.DEPTH (MAX_REGIONS)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	sra_ctrl #(
		.MAX_REGIONS (MAX_REGIONS),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.req_addr    (req_addr),
		.req_length  (req_length),
		.entry_index (entry_index),
		.base        (base_q),
		.top_lim     (top_q),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: load a finished result, drop it on transfer
	assign res_ready = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			or_q <= res;
		end
	end

	assign out_valid    = ov_q;
	assign status       = or_q.status;
	assign result_addr  = or_q.addr;
	assign result_slot  = or_q.slot;
	assign region_total = or_q.total;

endmodule

`default_nettype wire
